[sv/mwrot_pkg.sv]
// Shared constants, types and state codes of the multiword bit vector rotator.
package mwrot_pkg;

  localparam int MAX_WORDS = 64;
  localparam int WORD_W    = 32;
  localparam int IDX_W     = $clog2(MAX_WORDS);
  localparam int CNT_W     = IDX_W + 1;
  localparam int BS_W      = $clog2(WORD_W);
  localparam int DIVD_W    = WORD_W - BS_W;
  localparam int DSTEP_W   = $clog2(DIVD_W);
  localparam int ADDR_W    = IDX_W + 1;
  localparam int STORE_DEPTH = 2 * MAX_WORDS;
  localparam int Q_DEPTH   = 2;
  localparam int QP_W      = $clog2(Q_DEPTH);
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_VECTOR_WORDS   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_BITS     = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION_MODE = CFG_IDX_W'(2);

  typedef struct packed {
    logic [CNT_W-1:0]  words;
    logic [WORD_W-1:0] shift;
    logic              reverse;
  } cfg_t;

  // one rotation job handed from front to back
  typedef struct packed {
    logic              bank;
    logic [CNT_W-1:0]  words;
    logic [IDX_W-1:0]  ws;
    logic [BS_W-1:0]   bs;
  } job_t;

  // back reports a bank drained
  typedef struct packed {
    logic valid;
    logic bank;
  } rel_t;

  typedef enum logic [1:0] {
    FS_LOAD,
    FS_MOD,
    FS_PUSH
  } front_state_t;

  typedef enum logic {
    BS_IDLE,
    BS_RUN
  } back_state_t;

endpackage

[sv/mwrot_ram.sv]
// Generic single write port, single read port RAM with registered read.
module mwrot_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[sv/mwrot_front.sv]
// Front end: loads words into the store, reduces the shift and queues rotation jobs.
module mwrot_front
  import mwrot_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic              start,
  input  logic [WORD_W-1:0] data_word,
  output logic              busy,
  output logic              ram_we,
  output logic [ADDR_W-1:0] ram_waddr,
  output logic [WORD_W-1:0] ram_wdata,
  output logic              q_push,
  output job_t              q_job,
  input  logic              q_full,
  input  rel_t              rel
);

  front_state_t       state_r, state_nxt;
  logic               bank_r;
  logic [1:0]         bank_busy_r, bank_busy_nxt;
  logic [IDX_W-1:0]   cnt_r;
  logic [CNT_W-1:0]   w_r;
  logic [DIVD_W-1:0]  dvd_r;
  logic [IDX_W-1:0]   rem_r, rem_nxt;
  logic [DSTEP_W-1:0] step_r;
  logic [BS_W-1:0]    bs_r;
  logic               rev_r;

  logic [CNT_W-1:0]   w_act;
  logic [CNT_W-1:0]   cnt_inc;
  logic               accept;
  logic               last;
  logic               mod_done;
  logic [CNT_W-1:0]   trial;

  always_comb begin
    w_act = cfg.words;
    if (cfg.words == '0) begin
      w_act = CNT_W'(1);
    end else if (cfg.words > CNT_W'(MAX_WORDS)) begin
      w_act = CNT_W'(MAX_WORDS);
    end
  end

  assign cnt_inc  = {1'b0, cnt_r} + CNT_W'(1);
  assign last     = cnt_inc >= w_act;
  assign accept   = start && !busy;
  assign mod_done = step_r == DSTEP_W'(DIVD_W - 1);

  // restoring remainder step: one quotient bit a cycle
  assign trial = {rem_r, dvd_r[DIVD_W-1]};
  assign rem_nxt = (trial >= w_r) ? IDX_W'(trial - w_r) : trial[IDX_W-1:0];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FS_LOAD: if (accept && last) state_nxt = FS_MOD;
      FS_MOD:  if (mod_done)       state_nxt = FS_PUSH;
      FS_PUSH: if (!q_full)        state_nxt = FS_LOAD;
      default: state_nxt = FS_LOAD;
    endcase
  end

  always_comb begin
    busy   = (state_r != FS_LOAD) || bank_busy_r[bank_r];
    ram_we = 1'b0;
    q_push = 1'b0;
    unique case (state_r)
      FS_LOAD: ram_we = start && !bank_busy_r[bank_r];
      FS_MOD:  ram_we = 1'b0;
      FS_PUSH: q_push = !q_full;
      default: ram_we = 1'b0;
    endcase
  end

  assign ram_waddr = {bank_r, cnt_r};
  assign ram_wdata = data_word;

  // reverse: total - eff, folded back into word and bit offsets
  always_comb begin
    q_job.bank  = bank_r;
    q_job.words = w_r;
    q_job.ws    = rem_r;
    q_job.bs    = bs_r;
    if (rev_r) begin
      if (bs_r == '0) begin
        q_job.ws = (rem_r == '0) ? '0 : IDX_W'(w_r - {1'b0, rem_r});
      end else begin
        q_job.ws = IDX_W'(w_r - {1'b0, rem_r} - CNT_W'(1));
        q_job.bs = BS_W'((BS_W+1)'(WORD_W) - {1'b0, bs_r});
      end
    end
  end

  always_comb begin
    bank_busy_nxt = bank_busy_r;
    if (rel.valid) begin
      bank_busy_nxt[rel.bank] = 1'b0;
    end
    if (q_push) begin
      bank_busy_nxt[bank_r] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FS_LOAD;
      bank_r      <= 1'b0;
      bank_busy_r <= '0;
      cnt_r       <= '0;
      step_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      bank_busy_r <= bank_busy_nxt;
      if (q_push) begin
        bank_r <= !bank_r;
      end
      if (accept) begin
        cnt_r <= last ? '0 : cnt_inc[IDX_W-1:0];
      end
      if (accept && last) begin
        step_r <= '0;
      end else if (state_r == FS_MOD) begin
        step_r <= step_r + DSTEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last) begin
      w_r   <= w_act;
      dvd_r <= cfg.shift[WORD_W-1:BS_W];
      bs_r  <= cfg.shift[BS_W-1:0];
      rev_r <= cfg.reverse;
      rem_r <= '0;
    end else if (state_r == FS_MOD) begin
      rem_r <= rem_nxt;
      dvd_r <= {dvd_r[DIVD_W-2:0], 1'b0};
    end
  end

endmodule

[sv/mwrot_queue.sv]
// Two-entry job queue between front and back.
module mwrot_queue
  import mwrot_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t pop_job,
  output logic full,
  output logic empty
);

  job_t            ent_r [Q_DEPTH];
  logic [QP_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QP_W:0]   cnt_r;

  assign full    = cnt_r == (QP_W+1)'(Q_DEPTH);
  assign empty   = cnt_r == '0;
  assign pop_job = ent_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QP_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QP_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + (QP_W+1)'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - (QP_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

[sv/mwrot_back.sv]
// Back end: streams a stored vector out of the RAM and splices rotated words.
module mwrot_back
  import mwrot_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  job_t              q_job,
  output logic              q_pop,
  output logic [ADDR_W-1:0] ram_raddr,
  input  logic [WORD_W-1:0] ram_rdata,
  output rel_t              rel,
  output logic              out_strobe,
  output logic [WORD_W-1:0] out_result_word,
  output logic              out_last_word
);

  back_state_t       state_r, state_nxt;
  job_t              job_r;
  logic [IDX_W-1:0]  ptr_r;
  logic [CNT_W-1:0]  rd_cnt_r;
  logic              rd_vld_r;
  logic [CNT_W-1:0]  d_cnt_r;
  logic [WORD_W-1:0] lo_r;
  logic              strobe_r;
  logic [WORD_W-1:0] word_r;
  logic              last_r;

  logic              issue;
  logic              emit;
  logic              fin;
  logic [IDX_W-1:0]  ptr_inc;
  logic [BS_W:0]     lsh;
  logic [WORD_W-1:0] word;

  // reads run lo(0), hi(0), hi(1) ... : each word reuses the previous read as lo
  assign ptr_inc = ({1'b0, ptr_r} + CNT_W'(1) == job_r.words) ? '0 : ptr_r + IDX_W'(1);
  assign emit    = rd_vld_r && (d_cnt_r != '0);
  assign fin     = emit && (d_cnt_r == job_r.words);
  assign lsh     = (BS_W+1)'(WORD_W) - {1'b0, job_r.bs};
  assign word    = (job_r.bs == '0) ? ram_rdata
                 : (ram_rdata >> job_r.bs) | (lo_r << lsh);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BS_IDLE: if (!q_empty) state_nxt = BS_RUN;
      BS_RUN:  if (fin)      state_nxt = BS_IDLE;
      default: state_nxt = BS_IDLE;
    endcase
  end

  always_comb begin
    q_pop = 1'b0;
    issue = 1'b0;
    unique case (state_r)
      BS_IDLE: q_pop = !q_empty;
      BS_RUN:  issue = rd_cnt_r <= job_r.words;
      default: q_pop = 1'b0;
    endcase
  end

  assign ram_raddr = {job_r.bank, ptr_r};
  assign rel.valid = fin;
  assign rel.bank  = job_r.bank;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= BS_IDLE;
      rd_vld_r <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= issue;
      strobe_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r    <= q_job;
      ptr_r    <= IDX_W'(q_job.words - CNT_W'(1) - {1'b0, q_job.ws});
      rd_cnt_r <= '0;
      d_cnt_r  <= '0;
    end else begin
      if (issue) begin
        ptr_r    <= ptr_inc;
        rd_cnt_r <= rd_cnt_r + CNT_W'(1);
      end
      if (rd_vld_r) begin
        d_cnt_r <= d_cnt_r + CNT_W'(1);
      end
    end
    if (rd_vld_r) begin
      lo_r <= ram_rdata;
    end
    word_r <= word;
    last_r <= fin;
  end

  assign out_strobe      = strobe_r;
  assign out_result_word = word_r;
  assign out_last_word   = last_r;

endmodule

[sv/multiword_bit_vector_rotator_core.sv]
// Multiword bit vector rotator: config registers, two-bank store, front, queue and back.
// A word is taken each cycle while busy is low; the last word of a vector is followed by
// shift reduction (one remainder bit a cycle), then the rotated words leave one per cycle.
// Loading overlaps emission through the two store banks. Reset clears control and config
// (W=1, shift 0, forward); store contents stay undefined and no clearing pass is run.
// Results cannot be stalled.
module multiword_bit_vector_rotator_core
  import mwrot_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_wdata,
  input  logic                 start,
  output logic                 busy,
  input  logic [WORD_W-1:0]    in_data_word,
  output logic                 out_strobe,
  output logic [WORD_W-1:0]    out_result_word,
  output logic                 out_last_word
);

  cfg_t              cfg_r;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [WORD_W-1:0] ram_rdata;
  logic              q_push;
  logic              q_pop;
  logic              q_full;
  logic              q_empty;
  job_t              q_in_job;
  job_t              q_out_job;
  rel_t              rel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.words   <= CNT_W'(1);
      cfg_r.shift   <= '0;
      cfg_r.reverse <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_VECTOR_WORDS:   cfg_r.words   <= cfg_wdata[CNT_W-1:0];
        CFG_SHIFT_BITS:     cfg_r.shift   <= cfg_wdata;
        CFG_DIRECTION_MODE: cfg_r.reverse <= cfg_wdata[0];
        default:            cfg_r         <= cfg_r;
      endcase
    end
  end

  mwrot_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .start     (start),
    .data_word (in_data_word),
    .busy      (busy),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .q_push    (q_push),
    .q_job     (q_in_job),
    .q_full    (q_full),
    .rel       (rel)
  );

  mwrot_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  mwrot_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_in_job),
    .pop      (q_pop),
    .pop_job  (q_out_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  mwrot_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_job           (q_out_job),
    .q_pop           (q_pop),
    .ram_raddr       (ram_raddr),
    .ram_rdata       (ram_rdata),
    .rel             (rel),
    .out_strobe      (out_strobe),
    .out_result_word (out_result_word),
    .out_last_word   (out_last_word)
  );

endmodule
